// ===== design/emulated_dma_block_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the emulated DMA block sequencer
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef EMULATED_DMA_BLOCK_SEQUENCER_MACROS_SVH
`define EMULATED_DMA_BLOCK_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define EDBS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define EDBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EDBS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define EDBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/edbs_pkg.sv =====
// ----------------------------------------------------------------------------
// edbs_pkg
// Types and constants shared by the emulated DMA block sequencer modules.
// ----------------------------------------------------------------------------
package edbs_pkg;

  // request kinds carried on the input beat
  typedef logic [2:0] req_t;
  localparam req_t REQ_TICK  = 3'd0;
  localparam req_t REQ_POLL  = 3'd1;
  localparam req_t REQ_ACK   = 3'd2;
  localparam req_t REQ_WRITE = 3'd3;
  localparam req_t REQ_DRAIN = 3'd4;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BLOCK_SIZE = 2'd0;
  localparam cfg_idx_t CFG_HOLDOFF    = 2'd1;
  localparam cfg_idx_t CFG_BUF_ADDR   = 2'd2;

  localparam int CFG_DATA_W = 20;

  // configuration reset values and limits
  localparam logic [12:0] BLOCK_SIZE_RST = 13'd128;
  localparam logic [15:0] HOLDOFF_RST    = 16'd100;
  localparam logic [19:0] BUF_ADDR_RST   = 20'd0;
  localparam logic [12:0] BLOCK_MIN      = 13'd2;
  localparam logic [12:0] BLOCK_MAX      = 13'd4096;
  localparam logic [15:0] TICK_MAX       = 16'hFFFF;

  // one channel register set as held in the channel memory
  typedef struct packed {
    logic [7:0]  page;
    logic [15:0] base;
    logic [15:0] count;
    logic        autoinit;
  } chan_entry_t;

  // channel memory write request
  typedef struct packed {
    logic        en;
    logic [2:0]  ch;
    chan_entry_t entry;
  } chan_wr_t;

  // unpacked input item
  typedef struct packed {
    req_t        req_type;
    logic [2:0]  channel;
    logic [7:0]  page;
    logic [15:0] base_addr;
    logic [15:0] base_count;
    logic        autoinit;
    logic [12:0] drain_count;
  } item_t;

  // one result item
  typedef struct packed {
    logic        copy_started;
    logic        irq_forced;
    logic [15:0] src_segment;
    logic [3:0]  src_offset;
    logic [15:0] dest_segment;
    logic [3:0]  dest_offset;
    logic [12:0] copy_length;
    logic [15:0] next_address;
    logic [15:0] next_count;
    logic [2:0]  channel_out;
    logic [12:0] level_out;
    logic        waiting;
  } result_t;

endpackage

// ===== design/edbs_chan_mem.sv =====
// ----------------------------------------------------------------------------
// edbs_chan_mem
// Per-channel register memory with written and changed marks per entry.
// ----------------------------------------------------------------------------
module edbs_chan_mem
  import edbs_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  chan_wr_t    wr,
  input  logic        rd_en,
  input  logic [2:0]  rd_ch,
  output chan_entry_t rd_data,
  input  logic [2:0]  chg_ch,
  input  logic        chg_clr,
  output logic        chg_flag
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [3:0] NCH = 4'(NUM_CHANNELS);

  chan_entry_t mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] written;
  logic [NUM_CHANNELS-1:0] changed;
  chan_entry_t rd_q;
  logic        rd_vld;

  logic            wr_ok, rd_ok, chg_ok;
  logic [CH_W-1:0] wr_idx, rd_idx, chg_idx;

  // range checks against the channel count
  always_comb begin
    wr_ok   = wr.en && ({1'b0, wr.ch} < NCH);
    rd_ok   = {1'b0, rd_ch} < NCH;
    chg_ok  = {1'b0, chg_ch} < NCH;
    wr_idx  = wr.ch[CH_W-1:0];
    rd_idx  = rd_ok ? rd_ch[CH_W-1:0] : '0;
    chg_idx = chg_ok ? chg_ch[CH_W-1:0] : '0;
  end

  // write and registered read; a write and a read at one edge come from the
  // same beat, which never needs its own read data
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_idx] <= wr.entry;
    end
    if (rd_en) begin
      rd_q   <= mem[rd_idx];
      rd_vld <= rd_ok && written[rd_idx];
    end
  end

  // an entry never written reads as zero
  assign rd_data = rd_vld ? rd_q : '0;

  // written and changed marks; a younger write wins over a poll's clear
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      changed <= '0;
    end else begin
      if (chg_clr && chg_ok) begin
        changed[chg_idx] <= 1'b0;
      end
      if (wr_ok) begin
        written[wr_idx] <= 1'b1;
        changed[wr_idx] <= 1'b1;
      end
    end
  end

  assign chg_flag = chg_ok && changed[chg_idx];

endmodule

// ===== design/edbs_xfer_engine.sv =====
// ----------------------------------------------------------------------------
// edbs_xfer_engine
// Transfer state and the per-beat update: ticks, polls, acks and drains.
// ----------------------------------------------------------------------------
module edbs_xfer_engine
  import edbs_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        proc,
  input  item_t       item,
  input  chan_entry_t chan,
  input  logic        chg_flag,
  input  logic [12:0] block_size,
  input  logic [15:0] holdoff_ticks,
  input  logic [19:0] buffer_address,
  output logic        chg_clr,
  output result_t     res
);

  localparam logic [3:0] NCH = 4'(NUM_CHANNELS);

  logic [23:0] start_address, start_address_next;
  logic [23:0] current_address, current_address_next;
  logic [16:0] total_size, total_size_next;
  logic [16:0] remaining, remaining_next;
  logic [12:0] chunk_length, chunk_length_next;
  logic [12:0] buf_fill, buf_fill_next;
  logic        wait_ack, wait_ack_next;
  logic [31:0] sent_count, sent_count_next;
  logic [31:0] acked_count, acked_count_next;
  logic [15:0] ticks_since_ack, ticks_since_ack_next;

  logic        gate, reload, issue, irq_forced;
  logic [23:0] eff_start, eff_cur, use_cur;
  logic [16:0] eff_total, eff_rem, use_rem, len_w;
  logic [12:0] bs_c, len;
  logic [13:0] thr;

  // poll decision: gate, reload of changed registers, autoinit rewind
  always_comb begin
    gate = !wait_ack && (ticks_since_ack >= holdoff_ticks) &&
           (buf_fill == '0) && ({1'b0, item.channel} < NCH);
    reload    = gate && chg_flag;
    eff_start = reload ? {chan.page, chan.base} : start_address;
    eff_cur   = reload ? {chan.page, chan.base} : current_address;
    eff_total = reload ? ({1'b0, chan.count} + 17'd1) : total_size;
    eff_rem   = reload ? ({1'b0, chan.count} + 17'd1) : remaining;
    issue     = gate && (eff_total != '0) && ((eff_rem != '0) || chan.autoinit);
    use_rem   = (eff_rem == '0) ? eff_total : eff_rem;
    use_cur   = (eff_rem == '0) ? eff_start : eff_cur;
  end

  // chunk by the block / 1.5-block rule
  always_comb begin
    if (block_size < BLOCK_MIN) begin
      bs_c = BLOCK_MIN;
    end else if (block_size > BLOCK_MAX) begin
      bs_c = BLOCK_MAX;
    end else begin
      bs_c = block_size;
    end
    thr   = {1'b0, bs_c} + {2'b0, bs_c[12:1]};
    len_w = (use_rem < {3'b0, thr}) ? use_rem : {4'b0, bs_c};
    len   = len_w[12:0];
    irq_forced = sent_count != acked_count;
  end

  // next state for each request kind
  always_comb begin
    start_address_next   = start_address;
    current_address_next = current_address;
    total_size_next      = total_size;
    remaining_next       = remaining;
    chunk_length_next    = chunk_length;
    buf_fill_next        = buf_fill;
    wait_ack_next        = wait_ack;
    sent_count_next      = sent_count;
    acked_count_next     = acked_count;
    ticks_since_ack_next = ticks_since_ack;
    unique case (item.req_type)
      REQ_TICK: begin
        if (ticks_since_ack != TICK_MAX) begin
          ticks_since_ack_next = ticks_since_ack + 16'd1;
        end
      end
      REQ_POLL: begin
        if (gate) begin
          start_address_next   = eff_start;
          current_address_next = eff_cur;
          total_size_next      = eff_total;
          remaining_next       = eff_rem;
        end
        if (issue) begin
          current_address_next = use_cur;
          remaining_next       = use_rem;
          chunk_length_next    = len;
          wait_ack_next        = 1'b1;
          sent_count_next      = irq_forced ? 32'd1 : sent_count + 32'd1;
          acked_count_next     = irq_forced ? 32'd0 : acked_count;
        end
      end
      REQ_ACK: begin
        remaining_next = (remaining > {4'b0, chunk_length}) ?
                         remaining - {4'b0, chunk_length} : '0;
        current_address_next = current_address + {11'b0, chunk_length};
        buf_fill_next        = chunk_length;
        wait_ack_next        = 1'b0;
        acked_count_next     = acked_count + 32'd1;
        ticks_since_ack_next = '0;
      end
      REQ_DRAIN: begin
        buf_fill_next = (buf_fill > item.drain_count) ?
                        buf_fill - item.drain_count : '0;
      end
      default: begin
      end
    endcase
  end

  // commit state when the beat is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address   <= '0;
      current_address <= '0;
      total_size      <= '0;
      remaining       <= '0;
      chunk_length    <= '0;
      buf_fill        <= '0;
      wait_ack        <= 1'b0;
      sent_count      <= '0;
      acked_count     <= '0;
      ticks_since_ack <= '0;
    end else if (proc) begin
      start_address   <= start_address_next;
      current_address <= current_address_next;
      total_size      <= total_size_next;
      remaining       <= remaining_next;
      chunk_length    <= chunk_length_next;
      buf_fill        <= buf_fill_next;
      wait_ack        <= wait_ack_next;
      sent_count      <= sent_count_next;
      acked_count     <= acked_count_next;
      ticks_since_ack <= ticks_since_ack_next;
    end
  end

  assign chg_clr = proc && (item.req_type == REQ_POLL) && reload;

  // build the result beat
  always_comb begin
    res = '0;
    if ((item.req_type == REQ_POLL) && issue) begin
      res.copy_started = 1'b1;
      res.irq_forced   = irq_forced;
      res.src_segment  = use_cur[19:4];
      res.src_offset   = use_cur[3:0];
      res.dest_segment = buffer_address[19:4];
      res.dest_offset  = buffer_address[3:0];
      res.copy_length  = len;
      res.next_address = use_cur[15:0] + {3'b0, len};
      res.next_count   = use_rem[15:0] - {3'b0, len} - 16'd1;
      res.channel_out  = item.channel;
    end
    res.level_out = buf_fill_next;
    res.waiting   = wait_ack_next;
  end

endmodule

// ===== design/emulated_dma_block_sequencer.sv =====
// ----------------------------------------------------------------------------
// emulated_dma_block_sequencer
// Turns DMA channel programming and transfer polls into block copy requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one event per beat: s_tuser is the request kind (tick, poll,
//   ack, channel register write, buffer drain), s_tdata the operands.
//   m_* returns exactly one result beat per input beat; m_tuser marks a beat
//   that issued a copy request, m_tdata holds its segment:offset parameters,
//   the buffer level and the wait-for-ack flag.
//   cfg_we/cfg_index/cfg_data write block size, hold-off and buffer address;
//   write them only while no beat is in flight.
// Pipeline and rate:
//   An input beat is taken into the memory stage, where the channel memory
//   is read as the beat is accepted; the transfer update then lands in the
//   output register. One beat is taken every cycle while the output is not
//   stalled by m_tready.
// Reset:
//   rst clears all channels to zero, the transfer state and the counters,
//   and loads block size 128, hold-off 100 and buffer address 0.
// Backpressure:
//   While a result waits on low m_tready the output register and the memory
//   stage hold; s_tready stays high as long as the memory stage has room.
// ----------------------------------------------------------------------------
`include "emulated_dma_block_sequencer_macros.svh"

module emulated_dma_block_sequencer
  import edbs_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // slave side
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [2:0] channel, [10:3] page, [26:11] base_addr, [42:27] base_count,
  // [43] autoinit, [56:44] drain_count
  input  logic [63:0]           s_tdata,
  // [2:0] req_type
  input  logic [2:0]            s_tuser,
  // master side
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] irq_forced, [16:1] src_segment, [20:17] src_offset,
  // [36:21] dest_segment, [40:37] dest_offset, [53:41] copy_length,
  // [69:54] next_address, [85:70] next_count, [88:86] channel_out,
  // [101:89] level_out, [102] waiting
  output logic [103:0]          m_tdata,
  // [0] copy_started
  output logic [0:0]            m_tuser,
  // configuration
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [12:0] block_size;
  logic [15:0] holdoff_ticks;
  logic [19:0] buffer_address;

  item_t       in_item, s1_item;
  logic        s1_valid, adv, accept, proc;
  chan_wr_t    wr;
  chan_entry_t chan;
  logic        chg_flag, chg_clr;
  result_t     res, out_res;
  logic        out_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size     <= BLOCK_SIZE_RST;
      holdoff_ticks  <= HOLDOFF_RST;
      buffer_address <= BUF_ADDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_SIZE: block_size     <= cfg_data[12:0];
        CFG_HOLDOFF:    holdoff_ticks  <= cfg_data[15:0];
        CFG_BUF_ADDR:   buffer_address <= cfg_data[19:0];
        default: begin
        end
      endcase
    end
  end

  // unpack the input beat
  always_comb begin
    in_item.req_type    = s_tuser;
    in_item.channel     = s_tdata[2:0];
    in_item.page        = s_tdata[10:3];
    in_item.base_addr   = s_tdata[26:11];
    in_item.base_count  = s_tdata[42:27];
    in_item.autoinit    = s_tdata[43];
    in_item.drain_count = s_tdata[56:44];
  end

  // pipeline flow: memory stage then output register
  assign adv      = !out_valid || m_tready;
  assign s_tready = !s1_valid || adv;
  assign accept   = s_tvalid && s_tready;
  assign proc     = s1_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

  // channel register writes go to memory as the beat is taken
  always_comb begin
    wr.en             = accept && (in_item.req_type == REQ_WRITE);
    wr.ch             = in_item.channel;
    wr.entry.page     = in_item.page;
    wr.entry.base     = in_item.base_addr;
    wr.entry.count    = in_item.base_count;
    wr.entry.autoinit = in_item.autoinit;
  end

  edbs_chan_mem #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_chan_mem (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (accept),
    .rd_ch   (in_item.channel),
    .rd_data (chan),
    .chg_ch  (s1_item.channel),
    .chg_clr (chg_clr),
    .chg_flag(chg_flag)
  );

  edbs_xfer_engine #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_xfer (
    .clk           (clk),
    .rst           (rst),
    .proc          (proc),
    .item          (s1_item),
    .chan          (chan),
    .chg_flag      (chg_flag),
    .block_size    (block_size),
    .holdoff_ticks (holdoff_ticks),
    .buffer_address(buffer_address),
    .chg_clr       (chg_clr),
    .res           (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_res <= res;
    end
  end

  // pack the result beat
  assign m_tvalid        = out_valid;
  assign m_tuser[0]      = out_res.copy_started;
  assign m_tdata[0]      = out_res.irq_forced;
  assign m_tdata[16:1]   = out_res.src_segment;
  assign m_tdata[20:17]  = out_res.src_offset;
  assign m_tdata[36:21]  = out_res.dest_segment;
  assign m_tdata[40:37]  = out_res.dest_offset;
  assign m_tdata[53:41]  = out_res.copy_length;
  assign m_tdata[69:54]  = out_res.next_address;
  assign m_tdata[85:70]  = out_res.next_count;
  assign m_tdata[88:86]  = out_res.channel_out;
  assign m_tdata[101:89] = out_res.level_out;
  assign m_tdata[102]    = out_res.waiting;
  assign m_tdata[103]    = 1'b0;

  // checks
  `EDBS_ASSERT_IMPLY(a_hold_when_full, clk, rst, s1_valid && !adv, !s_tready,
    "input taken while memory stage is blocked")
  `EDBS_ASSERT_NEXT(a_proc_fills_out, clk, rst, proc, out_valid,
    "processed beat did not reach the output register")
  `EDBS_ASSERT_IMPLY(a_copy_waits, clk, rst, out_valid && out_res.copy_started,
    out_res.waiting, "copy issued without waiting for ack")
  `EDBS_ASSERT_IMPLY(a_copy_sane, clk, rst, out_valid && out_res.copy_started,
    out_res.copy_length != '0 && out_res.level_out == '0,
    "copy issued with zero length or non-empty buffer")

endmodule
